FILE: sv/assert_macros.svh
// Assertion macros used by the port-level checker of the UTF-8 validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SUV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle property violated");

// Consequent must hold in the cycle after the antecedent.
`define SUV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle property violated");

`endif

FILE: sv/suv_pkg.sv
// Types and constants of the strict UTF-8 validator.
package suv_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic        is_valid;
    logic [31:0] error_offset;
  } out_t;

  // Item handed from the input register to the checking core.
  typedef struct packed {
    logic valid;
    in_t  data;
  } item_t;

  // Result handed from the checking core to the result register.
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] CpMin2   = 21'h00080;
  localparam logic [CpWidth-1:0] CpMin3   = 21'h00800;
  localparam logic [CpWidth-1:0] CpMin4   = 21'h10000;
  localparam logic [CpWidth-1:0] SurrLo   = 21'h0D800;
  localparam logic [CpWidth-1:0] SurrHi   = 21'h0DFFF;
  localparam logic [CpWidth-1:0] CpMax    = 21'h10FFFF;

  localparam logic [1:0] SeqLen2 = 2'd1;
  localparam logic [1:0] SeqLen3 = 2'd2;
  localparam logic [1:0] SeqLen4 = 2'd3;

  localparam logic [1:0] ContTag = 2'b10;

endpackage

FILE: sv/suv_input_stage.sv
// Input register of the validator with its stall logic.
module suv_input_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  suv_pkg::in_t  in_data_i,
  input  logic          out_blocked_i,
  output suv_pkg::item_t item_o
);
  import suv_pkg::*;

  logic vld_q;
  logic vld_d;
  in_t  data_q;
  logic take;
  logic accept;

  // A byte without the end mark never waits; a final byte waits for a free result register.
  assign take       = vld_q && !(data_q.end_of_input && out_blocked_i);
  assign in_stall_o = vld_q && !take;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign item_o.valid = take;
  assign item_o.data  = data_q;

endmodule

FILE: sv/suv_core.sv
// Sequence state and per-byte checking logic of the validator.
module suv_core #(
  parameter int unsigned OffsetWidth = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  suv_pkg::item_t item_i,
  output suv_pkg::res_t  res_o
);
  import suv_pkg::*;

  logic [OffsetWidth-1:0] pos_q, pos_d, lead_q, lead_d, cbad_pos_q, cbad_pos_d;
  logic [OffsetWidth-1:0] fail_pos_q, fail_pos_d, pos_next;
  logic [1:0]             rem_q, rem_d, len_q, len_d, extra, rem_new;
  logic [CpWidth-1:0]     acc_q, acc_d, payload, acc_new;
  logic                   cbad_q, cbad_d, failed_q, failed_d, bad_lead, bad_cp;
  logic [7:0]             b;
  logic                   last;

  assign b        = item_i.data.data_byte;
  assign last     = item_i.data.end_of_input;
  assign pos_next = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign acc_new  = {acc_q[CpWidth-7:0], b[5:0]};
  assign rem_new  = rem_q - 2'd1;

  always_comb begin
    extra    = 2'd0;
    payload  = '0;
    bad_lead = 1'b0;
    case (b) inside
      [8'h00:8'h7F]: extra = 2'd0;
      [8'hC0:8'hDF]: begin
        extra   = SeqLen2;
        payload = CpWidth'(b[4:0]);
      end
      [8'hE0:8'hEF]: begin
        extra   = SeqLen3;
        payload = CpWidth'(b[3:0]);
      end
      [8'hF0:8'hF7]: begin
        extra   = SeqLen4;
        payload = CpWidth'(b[2:0]);
      end
      default: bad_lead = 1'b1;
    endcase
  end

  assign bad_cp = ((len_q == SeqLen2) && (acc_new < CpMin2)) ||
                  ((len_q == SeqLen3) && (acc_new < CpMin3)) ||
                  ((len_q == SeqLen4) && (acc_new < CpMin4)) ||
                  ((acc_new >= SurrLo) && (acc_new <= SurrHi)) ||
                  (acc_new > CpMax);

  always_comb begin
    pos_d      = pos_q;
    rem_d      = rem_q;
    len_d      = len_q;
    acc_d      = acc_q;
    lead_d     = lead_q;
    cbad_d     = cbad_q;
    cbad_pos_d = cbad_pos_q;
    failed_d   = failed_q;
    fail_pos_d = fail_pos_q;
    if (item_i.valid) begin
      pos_d = pos_next;
      if (!failed_q) begin
        if (rem_q == 2'd0) begin
          if (bad_lead || ((extra != 2'd0) && last)) begin
            failed_d   = 1'b1;
            fail_pos_d = pos_q;
          end else if (extra != 2'd0) begin
            rem_d      = extra;
            len_d      = extra;
            acc_d      = payload;
            lead_d     = pos_q;
            cbad_d     = 1'b0;
            cbad_pos_d = '0;
          end
        end else begin
          if ((b[7:6] != ContTag) && !cbad_q) begin
            cbad_d     = 1'b1;
            cbad_pos_d = pos_q;
          end
          acc_d = acc_new;
          rem_d = rem_new;
          if (rem_new == 2'd0) begin
            if (cbad_d) begin
              failed_d   = 1'b1;
              fail_pos_d = cbad_pos_d;
            end else if (bad_cp) begin
              failed_d   = 1'b1;
              fail_pos_d = lead_q;
            end
          end else if (last) begin
            failed_d   = 1'b1;
            fail_pos_d = lead_q;
            rem_d      = 2'd0;
          end
        end
      end
      if (last) begin
        pos_d      = '0;
        rem_d      = 2'd0;
        len_d      = 2'd0;
        acc_d      = '0;
        lead_d     = '0;
        cbad_d     = 1'b0;
        cbad_pos_d = '0;
        failed_d   = 1'b0;
        fail_pos_d = '0;
      end
    end
  end

  logic                   res_failed;
  logic [OffsetWidth-1:0] res_pos;
  logic [63:0]            res_pos_ext;

  // The result is taken from the values after this byte, before the end clears them.
  always_comb begin
    res_failed = failed_q;
    res_pos    = fail_pos_q;
    if (!failed_q) begin
      if (rem_q == 2'd0) begin
        if (bad_lead || (extra != 2'd0)) begin
          res_failed = 1'b1;
          res_pos    = pos_q;
        end
      end else if (rem_new == 2'd0) begin
        if ((b[7:6] != ContTag) || cbad_q) begin
          res_failed = 1'b1;
          res_pos    = cbad_q ? cbad_pos_q : pos_q;
        end else if (bad_cp) begin
          res_failed = 1'b1;
          res_pos    = lead_q;
        end
      end else begin
        res_failed = 1'b1;
        res_pos    = lead_q;
      end
    end
  end

  assign res_pos_ext = 64'(res_pos);

  assign res_o.valid             = item_i.valid && last;
  assign res_o.data.is_valid     = !res_failed;
  assign res_o.data.error_offset = res_failed ? res_pos_ext[31:0] : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      rem_q      <= 2'd0;
      len_q      <= 2'd0;
      acc_q      <= '0;
      lead_q     <= '0;
      cbad_q     <= 1'b0;
      cbad_pos_q <= '0;
      failed_q   <= 1'b0;
      fail_pos_q <= '0;
    end else begin
      pos_q      <= pos_d;
      rem_q      <= rem_d;
      len_q      <= len_d;
      acc_q      <= acc_d;
      lead_q     <= lead_d;
      cbad_q     <= cbad_d;
      cbad_pos_q <= cbad_pos_d;
      failed_q   <= failed_d;
      fail_pos_q <= fail_pos_d;
    end
  end

endmodule

FILE: sv/suv_output_stage.sv
// Result register of the validator.
module suv_output_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  suv_pkg::res_t res_i,
  output logic          out_blocked_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output suv_pkg::out_t out_data_o
);
  import suv_pkg::*;

  logic vld_q;
  logic vld_d;
  out_t data_q;

  assign out_blocked_o = vld_q && out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (res_i.valid) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

FILE: sv/strict_utf8_validator.sv
// Top level of the strict UTF-8 validator.
// The block takes one message byte per transfer, at up to one byte per clock, and
// gives one result transfer for each byte marked end_of_input: is_valid, and the
// offset of the first error when the message is not strict UTF-8. Each byte goes
// through an input register and then the combinational sequence checking into the result
// register, from which the result is offered. Only a
// final byte waits while an earlier result is still stalled at the output; other
// bytes keep flowing. The byte offset is OFFSET_WIDTH bits wide and saturates.
module strict_utf8_validator #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  suv_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output suv_pkg::out_t out_data_o
);
  import suv_pkg::*;

  item_t item;
  res_t  res;
  logic  out_blocked;

  suv_input_stage u_input_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_blocked_i (out_blocked),
    .item_o        (item)
  );

  suv_core #(
    .OffsetWidth (OFFSET_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .res_o  (res)
  );

  suv_output_stage u_output_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .out_blocked_o (out_blocked),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

FILE: sv/suv_checker.sv
// Port-level checker of the validator and its bind to the top level.
`include "assert_macros.svh"

module suv_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input suv_pkg::out_t out_data_o
);
  import suv_pkg::*;

  `SUV_ASSERT_IMP(valid_has_zero_offset, clk_i, rst_ni, out_valid_o && out_data_o.is_valid, out_data_o.error_offset == 32'd0)
  `SUV_ASSERT_IMP(stall_only_on_blocked_output, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `SUV_ASSERT_NXT(held_result_stays, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `SUV_ASSERT_IMP(result_leaves_only_when_taken, clk_i, rst_ni, $fell(out_valid_o), $past(!out_stall_i))

endmodule

bind strict_utf8_validator suv_checker u_suv_checker (.*);
